// ===== design/assert_macros.svh =====
// assertion helpers included by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every rising clock edge outside reset
`define SVA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// condition must never be seen outside reset
`define SVA_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define SVA_ASSERT(label, clk, rst_n, prop)
`define SVA_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ===== design/sva_pkg.sv =====
package sva_pkg;

  localparam int ENTITY_W = 16;
  localparam int CHAN_W   = 4;
  localparam int NOW_W    = 31;
  localparam int LEN_W    = 24;
  localparam int TIME_W   = 32;
  localparam int SLOT_W   = 3;

  localparam logic [TIME_W-1:0] LIFE_LIMIT = 32'h7fff_ffff;
  localparam logic [CHAN_W-1:0] CHAN_NONE  = 4'h0;
  localparam logic [CHAN_W-1:0] CHAN_ANY   = 4'hf;

  typedef enum logic {
    MODE_START = 1'b0,
    MODE_STOP  = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    STAT_GRANTED   = 2'd0,
    STAT_NO_SLOT   = 2'd1,
    STAT_STOPPED   = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  // one stored voice slot, active bit kept apart
  typedef struct packed {
    logic [ENTITY_W-1:0] owner;
    logic [CHAN_W-1:0]   chan;
    logic [TIME_W-1:0]   end_time;
  } slot_word_t;

  // latched request
  typedef struct packed {
    mode_t               mode;
    logic [ENTITY_W-1:0] entity;
    logic [CHAN_W-1:0]   chan;
    logic [NOW_W-1:0]    now;
    logic [LEN_W-1:0]    len;
    logic                audible;
  } req_t;

endpackage

// ===== design/sva_if.sv =====
// request channel
interface sva_in_if import sva_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [ENTITY_W-1:0]        entity;
  logic signed [CHAN_W-1:0]   ent_channel;
  logic [NOW_W-1:0]           current_time;
  logic [LEN_W-1:0]           sound_length;
  logic                       audible;

  modport source (
    output valid, mode, entity, ent_channel, current_time, sound_length, audible,
    input  ready
  );
  modport sink (
    input  valid, mode, entity, ent_channel, current_time, sound_length, audible,
    output ready
  );
endinterface

// result channel
interface sva_out_if import sva_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [SLOT_W-1:0] slot;

  modport source (
    output valid, status, slot,
    input  ready
  );
  modport sink (
    input  valid, status, slot,
    output ready
  );
endinterface

// ===== design/sound_voice_allocator_unit.sv =====
// the result is registered out of the finish step once the scan ends, early on a match
// requests are taken one at a time, paced by the one-slot-per-cycle scan through the slot
//   memory (one write and one read port) and the shared life subtract/compare unit
// the block takes no request while a scan is running
// reset (rst_n low, synchronous): all slots read as empty and inactive, viewer entity 0
module sound_voice_allocator_unit import sva_pkg::*; #(
  parameter int DYNAMIC_SLOTS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [ENTITY_W-1:0] cfg_wdata,
  sva_in_if.sink              in_ch,
  sva_out_if.source           out_ch
);

`include "assert_macros.svh"

  localparam int IDXW = (DYNAMIC_SLOTS > 1) ? $clog2(DYNAMIC_SLOTS) : 1;
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(DYNAMIC_SLOTS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t              state_r;
  req_t                req_r;
  logic [ENTITY_W-1:0] viewer_r;
  logic [IDXW-1:0]     rd_idx_r;
  logic                issue_done_r;
  logic                ev_vld_r;
  logic [IDXW-1:0]     ev_idx_r;
  logic [TIME_W-1:0]   best_r;
  logic [IDXW-1:0]     pick_r;
  logic                found_r;
  logic                out_valid_r;
  status_t             out_status_r;
  logic [SLOT_W-1:0]   out_slot_r;

  // slot storage
  slot_word_t          slot_mem [DYNAMIC_SLOTS];
  logic [DYNAMIC_SLOTS-1:0] slot_vld_r;
  logic [DYNAMIC_SLOTS-1:0] slot_act_r;
  slot_word_t          rd_word_r;
  logic                rd_vld_r;
  logic                rd_act_r;

  logic                fin_go;
  logic                mem_we;
  slot_word_t          wr_word;

  logic [ENTITY_W-1:0] e_owner;
  logic [CHAN_W-1:0]   e_chan;
  logic [TIME_W-1:0]   e_end;
  logic [TIME_W-1:0]   life;
  logic                reuse_hit;
  logic                stop_hit;
  logic                hit;
  logic                protect;
  logic                better;

  // handshake ports
  assign in_ch.ready   = (state_r == ST_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.slot   = out_slot_r;

  // finish when the result register is free
  assign fin_go = (state_r == ST_FINISH) && (!out_valid_r || out_ch.ready);
  assign mem_we = fin_go && found_r;

  // rewritten slot: stop keeps owner and channel, which equal the request
  always_comb begin
    wr_word.owner    = req_r.entity;
    wr_word.chan     = req_r.chan;
    wr_word.end_time = '0;
    if (req_r.mode == MODE_START && req_r.audible) begin
      wr_word.end_time = TIME_W'({1'b0, req_r.now} + {8'd0, req_r.len});
    end
  end

  // slot memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[pick_r] <= wr_word;
    end
    rd_word_r <= slot_mem[rd_idx_r];
    rd_vld_r  <= slot_vld_r[rd_idx_r];
    rd_act_r  <= slot_act_r[rd_idx_r];
  end

  // written and active flags per slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= '0;
      slot_act_r <= '0;
    end else if (mem_we) begin
      slot_vld_r[pick_r] <= 1'b1;
      slot_act_r[pick_r] <= (req_r.mode == MODE_START) && req_r.audible;
    end
  end

  // examine the slot read last cycle
  always_comb begin
    e_owner   = rd_vld_r ? rd_word_r.owner    : '0;
    e_chan    = rd_vld_r ? rd_word_r.chan     : '0;
    e_end     = rd_vld_r ? rd_word_r.end_time : '0;
    life      = e_end - {1'b0, req_r.now};
    reuse_hit = (req_r.chan != CHAN_NONE) && (e_owner == req_r.entity) &&
                ((e_chan == req_r.chan) || (req_r.chan == CHAN_ANY));
    stop_hit  = (e_owner == req_r.entity) && (e_chan == req_r.chan);
    hit       = (req_r.mode == MODE_STOP) ? stop_hit : reuse_hit;
    protect   = (e_owner == viewer_r) && (req_r.entity != viewer_r) && rd_act_r;
    better    = (req_r.mode == MODE_START) && !protect &&
                ($signed(life) < $signed(best_r));
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      viewer_r     <= '0;
      ev_vld_r     <= 1'b0;
      issue_done_r <= 1'b0;
      rd_idx_r     <= '0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        viewer_r <= cfg_wdata;
      end
      if (out_valid_r && out_ch.ready && !fin_go) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          ev_vld_r <= 1'b0;
          if (in_ch.valid) begin
            req_r.mode    <= mode_t'(in_ch.mode);
            req_r.entity  <= in_ch.entity;
            req_r.chan    <= $unsigned(in_ch.ent_channel);
            req_r.now     <= in_ch.current_time;
            req_r.len     <= in_ch.sound_length;
            req_r.audible <= in_ch.audible;
            rd_idx_r      <= '0;
            issue_done_r  <= 1'b0;
            best_r        <= LIFE_LIMIT;
            pick_r        <= '0;
            found_r       <= 1'b0;
            state_r       <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // read side: one slot a cycle, stopped by an early match
          ev_vld_r <= !issue_done_r && !(ev_vld_r && hit);
          ev_idx_r <= rd_idx_r;
          if (!issue_done_r) begin
            if (rd_idx_r == LAST_IDX) begin
              issue_done_r <= 1'b1;
            end else begin
              rd_idx_r <= rd_idx_r + 1'b1;
            end
          end
          // compare side
          if (ev_vld_r) begin
            priority if (hit) begin
              found_r  <= 1'b1;
              pick_r   <= ev_idx_r;
              state_r  <= ST_FINISH;
            end else begin
              if (better) begin
                best_r  <= life;
                pick_r  <= ev_idx_r;
                found_r <= 1'b1;
              end
              if (ev_idx_r == LAST_IDX) begin
                state_r  <= ST_FINISH;
              end
            end
          end
        end
        ST_FINISH: begin
          ev_vld_r <= 1'b0;
          if (fin_go) begin
            out_valid_r <= 1'b1;
            out_slot_r  <= found_r ? SLOT_W'(pick_r) : '0;
            if (req_r.mode == MODE_STOP) begin
              out_status_r <= found_r ? STAT_STOPPED : STAT_NOT_FOUND;
            end else begin
              out_status_r <= found_r ? STAT_GRANTED : STAT_NO_SLOT;
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // a result only appears out of the finish step
  `SVA_ASSERT(a_result_from_finish, clk, rst_n, $rose(out_valid_r) |-> $past(state_r) == ST_FINISH)
  // a request transfer starts a scan
  `SVA_ASSERT(a_accept_scans, clk, rst_n, (in_ch.valid && in_ch.ready) |=> state_r == ST_SCAN)
  // failed requests report slot zero
  `SVA_NEVER(a_fail_slot_zero, clk, rst_n, out_valid_r && (out_status_r == STAT_NO_SLOT || out_status_r == STAT_NOT_FOUND) && out_slot_r != '0)
  // slot memory is only written when a result is produced
  `SVA_ASSERT(a_write_with_result, clk, rst_n, mem_we |=> out_valid_r && state_r == ST_IDLE)
  // compare stage only busy while scanning
  `SVA_NEVER(a_eval_outside_scan, clk, rst_n, ev_vld_r && state_r != ST_SCAN)

endmodule

// ===== sim/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sva_pkg::*;

  localparam int VOICE_SLOTS = 8;
  localparam int SCAN_CYCLES = VOICE_SLOTS + 2;
  localparam int QUIET_LIMIT = 4000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_ITEMS = 330;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
  } voice_outcome_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [ENTITY_W-1:0] cfg_wdata = '0;

  sva_in_if  in_ch ();
  sva_out_if out_ch ();

  sound_voice_allocator_unit #(.DYNAMIC_SLOTS(VOICE_SLOTS)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // shadow copy of the voice table and the listener register
  logic [ENTITY_W-1:0] voice_owner [VOICE_SLOTS];
  logic [CHAN_W-1:0]   voice_chan  [VOICE_SLOTS];
  logic [TIME_W-1:0]   voice_end   [VOICE_SLOTS];
  logic                voice_live  [VOICE_SLOTS];
  logic [ENTITY_W-1:0] listener;

  voice_outcome_t      outcomes_due [$];
  int                  mismatches = 0;
  int                  quiet_cycles = 0;
  int                  burst_left = 0;
  int                  long_hold_req = 0;
  logic [NOW_W-1:0]    run_clock = '0;
  logic [ENTITY_W-1:0] ent_pool [3];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // slot allocation and voice stealing, one request at a time
  function automatic voice_outcome_t allocate_voice(req_t r);
    voice_outcome_t           res;
    int                       pick;
    logic signed [TIME_W-1:0] best;
    logic signed [TIME_W-1:0] life;
    pick       = -1;
    best       = LIFE_LIMIT;
    res.status = STAT_NOT_FOUND;
    res.slot   = '0;
    if (r.mode == MODE_STOP) begin
      // exact owner and channel, active bit ignored
      for (int i = 0; i < VOICE_SLOTS; i++) begin
        if (voice_owner[i] == r.entity && voice_chan[i] == r.chan) begin
          voice_end[i]  = '0;
          voice_live[i] = 1'b0;
          res.status    = STAT_STOPPED;
          res.slot      = SLOT_W'(i);
          return res;
        end
      end
      return res;
    end
    for (int i = 0; i < VOICE_SLOTS; i++) begin
      // reuse of the same owner and channel wins outright
      if (r.chan != CHAN_NONE && voice_owner[i] == r.entity &&
          (voice_chan[i] == r.chan || r.chan == CHAN_ANY)) begin
        pick = i;
        break;
      end
      // listener voices are protected from other requesters
      if (!(voice_owner[i] == listener && r.entity != listener && voice_live[i])) begin
        life = voice_end[i] - {1'b0, r.now};
        if (life < best) begin
          best = life;
          pick = i;
        end
      end
    end
    if (pick < 0) begin
      res.status = STAT_NO_SLOT;
      return res;
    end
    voice_owner[pick] = r.entity;
    voice_chan[pick]  = r.chan;
    if (r.audible) begin
      voice_end[pick]  = {1'b0, r.now} + TIME_W'(r.len);
      voice_live[pick] = 1'b1;
    end else begin
      voice_end[pick]  = '0;
      voice_live[pick] = 1'b0;
    end
    res.status = STAT_GRANTED;
    res.slot   = SLOT_W'(pick);
    return res;
  endfunction

  function automatic req_t voice_req(mode_t m, logic [ENTITY_W-1:0] e,
                                     logic [CHAN_W-1:0] c, logic [NOW_W-1:0] t,
                                     logic [LEN_W-1:0] l, logic a);
    req_t r;
    r.mode    = m;
    r.entity  = e;
    r.chan    = c;
    r.now     = t;
    r.len     = l;
    r.audible = a;
    return r;
  endfunction

  // small entity pool so that reuse and stop hit often
  function automatic req_t random_request();
    req_t r;
    int   c;
    r.mode   = ($urandom_range(0, 9) < 3) ? MODE_STOP : MODE_START;
    r.entity = ($urandom_range(0, 9) == 0) ? ENTITY_W'($urandom)
                                           : ent_pool[$urandom_range(0, 2)];
    c        = $urandom_range(0, 9);
    r.chan   = (c >= 8) ? CHAN_ANY : CHAN_W'(c);
    run_clock = run_clock + NOW_W'($urandom_range(0, 3000));
    r.now    = ($urandom_range(0, 19) == 0) ? NOW_W'($urandom) : run_clock;
    case ($urandom_range(0, 9))
      0: begin
        r.len = '0;
      end
      1: begin
        r.len = '1;
      end
      2: begin
        r.len = LEN_W'($urandom);
      end
      default: begin
        r.len = LEN_W'($urandom_range(1, 20000));
      end
    endcase
    r.audible = ($urandom_range(0, 6) != 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= 40) begin
      $display("%0t: %s wrong, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // one request transfer, entered and left at a falling edge
  task automatic send_request(req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= r.mode;
    in_ch.entity       <= r.entity;
    in_ch.ent_channel  <= r.chan;
    in_ch.current_time <= r.now;
    in_ch.sound_length <= r.len;
    in_ch.audible      <= r.audible;
    do @(posedge clk); while (!(in_ch.valid === 1'b1 && in_ch.ready === 1'b1));
    outcomes_due.push_back(allocate_voice(r));
    @(negedge clk);
  endtask

  // drop the request and let the last scan finish
  task automatic drain_pipeline();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (outcomes_due.size() != 0) @(negedge clk);
    repeat (SCAN_CYCLES + 2) @(negedge clk);
  endtask

  task automatic write_viewer(logic [ENTITY_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    listener = v;
  endtask

  // empty table after reset, stop miss and field extremes
  task automatic test_reset_table();
    drain_pipeline();
    send_request(voice_req(MODE_STOP, 16'h0000, CHAN_NONE, '0, '0, 1'b0));
    send_request(voice_req(MODE_STOP, 16'hffff, 4'd7, '1, '1, 1'b1));
    send_request(voice_req(MODE_START, 16'hffff, 4'd7, '1, '1, 1'b1));
  endtask

  // listener fills seven slots, the last goes to another entity, a voice at the life limit is never stolen
  task automatic test_listener_protection();
    logic [ENTITY_W-1:0] lsn;
    lsn = 16'h1234;
    drain_pipeline();
    write_viewer(lsn);
    for (int c = 1; c <= 7; c++) begin
      send_request(voice_req(MODE_START, lsn, CHAN_W'(c), '0, 24'd1000, 1'b1));
    end
    send_request(voice_req(MODE_START, 16'd5, 4'd3, 31'h7f00_0000, 24'hff_ffff, 1'b1));
    send_request(voice_req(MODE_START, 16'd6, 4'd2, '0, 24'd50, 1'b1));
    send_request(voice_req(MODE_START, lsn, CHAN_NONE, '0, 24'd1, 1'b1));
  endtask

  // wildcard reuse, inaudible start, stop hit and miss, channel zero
  task automatic test_reuse_and_stop();
    logic [ENTITY_W-1:0] lsn;
    lsn = 16'h1234;
    drain_pipeline();
    send_request(voice_req(MODE_START, lsn, CHAN_ANY, 31'd500, 24'd80, 1'b1));
    send_request(voice_req(MODE_START, 16'd5, 4'd3, 31'd600, 24'd90, 1'b0));
    send_request(voice_req(MODE_STOP, 16'd5, 4'd3, 31'd700, '0, 1'b0));
    send_request(voice_req(MODE_STOP, lsn, CHAN_ANY, 31'd700, '0, 1'b0));
    send_request(voice_req(MODE_STOP, 16'd5, CHAN_NONE, 31'd700, '0, 1'b0));
    send_request(voice_req(MODE_START, lsn, CHAN_NONE, 31'd800, 24'd10, 1'b1));
  endtask

  // receiver holds off while requests keep coming
  task automatic test_result_backpressure();
    drain_pipeline();
    ent_pool[0] = listener;
    ent_pool[1] = 16'd5;
    ent_pool[2] = 16'd6;
    long_hold_req++;
    repeat (8) send_request(random_request());
  endtask

  // random traffic under several listener settings
  task automatic test_random_traffic();
    logic [ENTITY_W-1:0] phase_viewer [5];
    phase_viewer = '{16'h0000, 16'hffff, 16'h8000, 16'h0001, 16'h0000};
    phase_viewer[4] = ENTITY_W'($urandom);
    foreach (phase_viewer[p]) begin
      drain_pipeline();
      write_viewer(phase_viewer[p]);
      ent_pool[0] = phase_viewer[p];
      ent_pool[1] = (p == 1) ? 16'h0000 : ENTITY_W'($urandom);
      ent_pool[2] = (p == 1) ? 16'hfffe : ENTITY_W'($urandom);
      run_clock   = (p % 2 == 0) ? NOW_W'($urandom) : '0;
      repeat (PHASE_ITEMS) send_request(random_request());
    end
  endtask

  // receiver stall patterns plus the long hold-off
  initial begin : result_sink
    int hold_left;
    int hold_done;
    int pattern;
    int pattern_left;
    int tick;
    hold_left    = 0;
    hold_done    = 0;
    pattern      = 0;
    pattern_left = 0;
    tick         = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req != hold_done) begin
        hold_done = long_hold_req;
        hold_left = LONG_HOLD;
      end
      if (pattern_left == 0) begin
        pattern      = $urandom_range(0, 3);
        pattern_left = $urandom_range(16, 96);
      end
      pattern_left--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (pattern)
          0: begin
            out_ch.ready <= 1'b1;
          end
          1: begin
            out_ch.ready <= ($urandom_range(0, 1) == 1);
          end
          2: begin
            out_ch.ready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            out_ch.ready <= (tick % 3 != 0);
          end
        endcase
      end
    end
  end

  // compare each result transfer with the oldest outcome due
  always @(posedge clk) begin : result_check
    voice_outcome_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (outcomes_due.size() == 0) begin
        report_mismatch("unexpected result", 0, out_ch.status);
      end else begin
        want = outcomes_due.pop_front();
        if (out_ch.status !== want.status) begin
          report_mismatch("status", want.status, out_ch.status);
        end
        if (out_ch.slot !== want.slot) begin
          report_mismatch("slot", want.slot, out_ch.slot);
        end
      end
    end
  end

  // no transfer on either channel for too long
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : test_sequence
    in_ch.valid        = 1'b0;
    in_ch.mode         = 1'b0;
    in_ch.entity       = '0;
    in_ch.ent_channel  = '0;
    in_ch.current_time = '0;
    in_ch.sound_length = '0;
    in_ch.audible      = 1'b0;
    listener           = '0;
    for (int i = 0; i < VOICE_SLOTS; i++) begin
      voice_owner[i] = '0;
      voice_chan[i]  = '0;
      voice_end[i]   = '0;
      voice_live[i]  = 1'b0;
    end
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_table();
    test_listener_protection();
    test_reuse_and_stop();
    test_result_backpressure();
    test_random_traffic();
    drain_pipeline();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/sva_pkg.sv
design/sva_if.sv
design/sound_voice_allocator_unit.sv
sim/testbench.sv
